// ----- hdl/lfsm_pkg.sv -----
package lfsm_pkg;

  localparam int unsigned LevelW = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SettleW = 16;
  localparam int unsigned SpeedW = 15;
  localparam int unsigned SteerW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_TAPE_THRESHOLD   = 3'd0,
    REG_CENTER_THRESHOLD = 3'd1,
    REG_SETTLE_TIME      = 3'd2,
    REG_FORWARD_SPEED    = 3'd3,
    REG_TURN_SPEED       = 3'd4,
    REG_CRAWL_SPEED      = 3'd5
  } reg_idx_e;

  // follower states, one-hot
  typedef enum logic [3:0] {
    ST_FORWARD  = 4'b0001,
    ST_LEFT     = 4'b0010,
    ST_RIGHT    = 4'b0100,
    ST_RECOVERY = 4'b1000
  } follow_state_e;

  // external state codes on line_state
  localparam logic [1:0] CODE_FORWARD  = 2'd0;
  localparam logic [1:0] CODE_LEFT     = 2'd1;
  localparam logic [1:0] CODE_RIGHT    = 2'd2;
  localparam logic [1:0] CODE_RECOVERY = 2'd3;

  localparam logic [LevelW-1:0]  TapeThresholdRst   = 12'd2000;
  localparam logic [LevelW-1:0]  CenterThresholdRst = 12'd1500;
  localparam logic [SettleW-1:0] SettleTimeRst      = 16'd60;
  localparam logic [SpeedW-1:0]  ForwardSpeedRst    = 15'd1638;
  localparam logic [SpeedW-1:0]  TurnSpeedRst       = 15'd1843;
  localparam logic [SpeedW-1:0]  CrawlSpeedRst      = 15'd1229;

  typedef struct packed {
    logic [LevelW-1:0]  tape_level;
    logic [LevelW-1:0]  lock_level;
    logic [SettleW-1:0] settle_time_ms;
    logic [SpeedW-1:0]  forward_speed;
    logic [SpeedW-1:0]  steer_gain;
    logic [SpeedW-1:0]  crawl_speed;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] left_level;
    logic [LevelW-1:0] center_level;
    logic [LevelW-1:0] right_level;
    logic [TimeW-1:0]  time_ms;
  } item_t;

  typedef struct packed {
    follow_state_e    state;
    logic [TimeW-1:0] align_start_time;
    logic             driving;
  } fsm_state_t;

  typedef struct packed {
    logic [SpeedW-1:0]        target_velocity;
    logic signed [SteerW-1:0] steering;
    logic                     drive_enable;
    logic [1:0]               line_state;
  } result_t;

endpackage

// ----- hdl/line_follow_state_machine_unit.sv -----
// path: an accepted input beat is held in the input register, then its result in the result register
// throughput: one beat per cycle while the output is not stalled; the state update between
// the input register and the result register is combinational
// reset: state forward, align stamp zero, drive flag clear, registers at
// their defaults, both pipeline registers empty
module line_follow_state_machine_unit import lfsm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [LevelW-1:0]        left_level_i,
  input  logic [LevelW-1:0]        center_level_i,
  input  logic [LevelW-1:0]        right_level_i,
  input  logic [TimeW-1:0]         time_ms_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SpeedW-1:0]        target_velocity_o,
  output logic signed [SteerW-1:0] steering_o,
  output logic                     drive_enable_o,
  output logic [1:0]               line_state_o
);

  cfg_t       cfg_q;
  item_t      item_q;
  logic       in_valid_q;
  fsm_state_t st_q;
  fsm_state_t st_d;
  result_t    res_d;
  result_t    res_q;
  logic       out_valid_q;
  logic       advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tape_level     <= TapeThresholdRst;
      cfg_q.lock_level     <= CenterThresholdRst;
      cfg_q.settle_time_ms <= SettleTimeRst;
      cfg_q.forward_speed  <= ForwardSpeedRst;
      cfg_q.steer_gain     <= TurnSpeedRst;
      cfg_q.crawl_speed    <= CrawlSpeedRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TAPE_THRESHOLD:   cfg_q.tape_level     <= cfg_data_i[LevelW-1:0];
        REG_CENTER_THRESHOLD: cfg_q.lock_level     <= cfg_data_i[LevelW-1:0];
        REG_SETTLE_TIME:      cfg_q.settle_time_ms <= cfg_data_i[SettleW-1:0];
        REG_FORWARD_SPEED:    cfg_q.forward_speed  <= cfg_data_i[SpeedW-1:0];
        REG_TURN_SPEED:       cfg_q.steer_gain     <= cfg_data_i[SpeedW-1:0];
        REG_CRAWL_SPEED:      cfg_q.crawl_speed    <= cfg_data_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // the stored beat moves on when the result register is free or drains
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.left_level   <= left_level_i;
      item_q.center_level <= center_level_i;
      item_q.right_level  <= right_level_i;
      item_q.time_ms      <= time_ms_i;
    end
  end

  lfsm_step u_step (
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .cur_i  (st_q),
    .nxt_o  (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.state            <= ST_FORWARD;
      st_q.align_start_time <= '0;
      st_q.driving          <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      if (advance) begin
        st_q <= st_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign target_velocity_o = res_q.target_velocity;
  assign steering_o        = res_q.steering;
  assign drive_enable_o    = res_q.drive_enable;
  assign line_state_o      = res_q.line_state;

endmodule

// ----- hdl/lfsm_step.sv -----
module lfsm_step import lfsm_pkg::*; (
  input  cfg_t       cfg_i,
  input  item_t      item_i,
  input  fsm_state_t cur_i,
  output fsm_state_t nxt_o,
  output result_t    res_o
);

  logic             centered;
  logic             left_tape;
  logic             right_tape;
  logic [TimeW-1:0] elapsed;
  logic             settling;
  logic [SteerW-1:0] turn_ext;

  assign centered   = item_i.center_level < cfg_i.lock_level;
  assign left_tape  = item_i.left_level < cfg_i.tape_level;
  assign right_tape = item_i.right_level < cfg_i.tape_level;
  // wrapping difference
  assign elapsed    = item_i.time_ms - cur_i.align_start_time;
  assign settling   = elapsed < {{(TimeW-SettleW){1'b0}}, cfg_i.settle_time_ms};
  assign turn_ext   = {1'b0, cfg_i.steer_gain};

  always_comb begin
    nxt_o = cur_i;
    res_o.target_velocity = '0;
    res_o.steering        = '0;
    unique case (cur_i.state)
      ST_FORWARD: begin
        res_o.target_velocity = cfg_i.forward_speed;
        nxt_o.driving = 1'b1;
        if (!centered) begin
          if (left_tape && !right_tape) begin
            nxt_o.state = ST_LEFT;
            nxt_o.align_start_time = item_i.time_ms;
          end else if (right_tape && !left_tape) begin
            nxt_o.state = ST_RIGHT;
            nxt_o.align_start_time = item_i.time_ms;
          end else begin
            nxt_o.state = ST_RECOVERY;
          end
        end
      end
      ST_LEFT, ST_RIGHT: begin
        res_o.target_velocity = cfg_i.crawl_speed;
        res_o.steering = (cur_i.state == ST_LEFT) ? turn_ext : -turn_ext;
        nxt_o.driving = 1'b1;
        if (!settling && centered) begin
          nxt_o.state = ST_FORWARD;
        end
      end
      ST_RECOVERY: begin
        // darker side wins, ties go right
        nxt_o.state = (item_i.left_level < item_i.right_level) ? ST_LEFT : ST_RIGHT;
        nxt_o.align_start_time = item_i.time_ms;
      end
      default: begin
        nxt_o.state = ST_FORWARD;
      end
    endcase

    res_o.drive_enable = nxt_o.driving;
    unique case (nxt_o.state)
      ST_FORWARD:  res_o.line_state = CODE_FORWARD;
      ST_LEFT:     res_o.line_state = CODE_LEFT;
      ST_RIGHT:    res_o.line_state = CODE_RIGHT;
      ST_RECOVERY: res_o.line_state = CODE_RECOVERY;
      default:     res_o.line_state = CODE_FORWARD;
    endcase
  end

endmodule

// ----- tb/line_follow_checker.sv -----
`timescale 1ns / 1ps

module line_follow_checker import lfsm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [LevelW-1:0]        left_level_i,
  input  logic [LevelW-1:0]        center_level_i,
  input  logic [LevelW-1:0]        right_level_i,
  input  logic [TimeW-1:0]         time_ms_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [SpeedW-1:0]        target_velocity_i,
  input  logic signed [SteerW-1:0] steering_i,
  input  logic                     drive_enable_i,
  input  logic [1:0]               line_state_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);

  cfg_t             regs;
  logic [1:0]       follow_code;
  logic [TimeW-1:0] stamp_ms;
  logic             drive_flag;
  result_t          steer_cmd_q[$];
  result_t          want;

  function automatic void apply_reg_write(input logic [CfgIdxW-1:0] idx,
                                          input logic [CfgDataW-1:0] data);
    unique case (idx)
      REG_TAPE_THRESHOLD:   regs.tape_level = data[LevelW-1:0];
      REG_CENTER_THRESHOLD: regs.lock_level = data[LevelW-1:0];
      REG_SETTLE_TIME:      regs.settle_time_ms = data[SettleW-1:0];
      REG_FORWARD_SPEED:    regs.forward_speed = data[SpeedW-1:0];
      REG_TURN_SPEED:       regs.steer_gain = data[SpeedW-1:0];
      REG_CRAWL_SPEED:      regs.crawl_speed = data[SpeedW-1:0];
      default: ;
    endcase
  endfunction

  // speed, steering use the entry state; drive flag, code the advanced one
  function automatic result_t predict_steer_cmd(input logic [LevelW-1:0] left,
                                                input logic [LevelW-1:0] center,
                                                input logic [LevelW-1:0] right,
                                                input logic [TimeW-1:0]  now);
    result_t          res;
    logic             centered;
    logic             left_tape;
    logic             right_tape;
    logic [TimeW-1:0] elapsed;
    logic [SteerW-1:0] mag;
    centered   = center < regs.lock_level;
    left_tape  = left < regs.tape_level;
    right_tape = right < regs.tape_level;
    mag        = {1'b0, regs.steer_gain};
    res        = '0;
    unique case (follow_code)
      CODE_FORWARD: begin
        res.target_velocity = regs.forward_speed;
        drive_flag = 1'b1;
        if (!centered) begin
          if (left_tape && !right_tape) begin
            follow_code = CODE_LEFT;
            stamp_ms = now;
          end else if (right_tape && !left_tape) begin
            follow_code = CODE_RIGHT;
            stamp_ms = now;
          end else begin
            follow_code = CODE_RECOVERY;
          end
        end
      end
      CODE_LEFT, CODE_RIGHT: begin
        res.target_velocity = regs.crawl_speed;
        res.steering = (follow_code == CODE_LEFT) ? mag : (~mag + 1'b1);
        drive_flag = 1'b1;
        // wrapping difference so a timestamp rollover still counts forward
        elapsed = now - stamp_ms;
        if (elapsed >= TimeW'(regs.settle_time_ms) && centered) begin
          follow_code = CODE_FORWARD;
        end
      end
      default: begin
        // equal sides fall to the right
        follow_code = (left < right) ? CODE_LEFT : CODE_RIGHT;
        stamp_ms = now;
      end
    endcase
    res.drive_enable = drive_flag;
    res.line_state   = follow_code;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{tape_level:     TapeThresholdRst,
               lock_level:     CenterThresholdRst,
               settle_time_ms: SettleTimeRst,
               forward_speed:  ForwardSpeedRst,
               steer_gain:     TurnSpeedRst,
               crawl_speed:    CrawlSpeedRst};
      follow_code  = CODE_FORWARD;
      stamp_ms     = '0;
      drive_flag   = 1'b0;
      steer_cmd_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        apply_reg_write(cfg_index_i, cfg_data_i);
      end
      // check the output beat first so a same-edge input beat cannot match it
      if (out_valid_i && out_ready_i) begin
        if (steer_cmd_q.size() == 0) begin
          $error("output beat with no expected result");
          fail_count_o++;
        end else begin
          want = steer_cmd_q.pop_front();
          checked_o++;
          if (target_velocity_i !== want.target_velocity) begin
            $error("target_velocity: expected %0d, actual %0d",
                   want.target_velocity, target_velocity_i);
            fail_count_o++;
          end
          if (steering_i !== want.steering) begin
            $error("steering: expected %0d, actual %0d",
                   $signed(want.steering), $signed(steering_i));
            fail_count_o++;
          end
          if (drive_enable_i !== want.drive_enable) begin
            $error("drive_enable: expected %0d, actual %0d",
                   want.drive_enable, drive_enable_i);
            fail_count_o++;
          end
          if (line_state_i !== want.line_state) begin
            $error("line_state: expected %0d, actual %0d", want.line_state, line_state_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        steer_cmd_q.push_back(predict_steer_cmd(left_level_i, center_level_i,
                                                right_level_i, time_ms_i));
      end
      pending_o = steer_cmd_q.size();
    end
  end

endmodule

// ----- tb/tb_line_follow_state_machine_unit.sv -----
`timescale 1ns / 1ps

module tb_line_follow_state_machine_unit import lfsm_pkg::*; ();

  localparam logic [CfgIdxW-1:0] StrayIdxLo = 3'd6;
  localparam logic [CfgIdxW-1:0] StrayIdxHi = 3'd7;
  localparam logic [LevelW-1:0]  LevelMax   = '1;
  localparam int unsigned        PhaseItems = 80;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [CfgDataW-1:0]      cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [LevelW-1:0]        left_level_i;
  logic [LevelW-1:0]        center_level_i;
  logic [LevelW-1:0]        right_level_i;
  logic [TimeW-1:0]         time_ms_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [SpeedW-1:0]        target_velocity_o;
  logic signed [SteerW-1:0] steering_o;
  logic                     drive_enable_o;
  logic [1:0]               line_state_o;

  int unsigned fail_count;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  int unsigned beats_sent;
  int unsigned reg_writes;
  bit          no_idle;

  // stimulus-side copy of the thresholds, used to aim readings around them
  logic [LevelW-1:0]  tape_th;
  logic [LevelW-1:0]  center_th;
  logic [SettleW-1:0] settle_ms;
  logic [TimeW-1:0]   now_ms;

  line_follow_state_machine_unit DUT (.*);

  line_follow_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .left_level_i      (left_level_i),
    .center_level_i    (center_level_i),
    .right_level_i     (right_level_i),
    .time_ms_i         (time_ms_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .target_velocity_i (target_velocity_o),
    .steering_i        (steering_o),
    .drive_enable_i    (drive_enable_o),
    .line_state_i      (line_state_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending_cnt),
    .checked_o         (checked_cnt)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= 36);
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // all tasks are entered and left just after a falling edge
  task automatic send_reading(input logic [LevelW-1:0] left, input logic [LevelW-1:0] center,
                              input logic [LevelW-1:0] right, input logic [TimeW-1:0] now);
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    left_level_i   <= left;
    center_level_i <= center;
    right_level_i  <= right;
    time_ms_i      <= now;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    unique case (idx)
      REG_TAPE_THRESHOLD:   tape_th = data[LevelW-1:0];
      REG_CENTER_THRESHOLD: center_th = data[LevelW-1:0];
      REG_SETTLE_TIME:      settle_ms = data[SettleW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // drain the pipeline, load all six registers; dirty junks unused bits and idx 6-7
  task automatic load_follow_regs(input logic [LevelW-1:0] tape, input logic [LevelW-1:0] center,
                                  input logic [SettleW-1:0] settle,
                                  input logic [SpeedW-1:0] fwd, input logic [SpeedW-1:0] turn,
                                  input logic [SpeedW-1:0] crawl, input bit dirty);
    logic [CfgDataW-1:0] junk;
    junk = dirty ? CfgDataW'($urandom()) : '0;
    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    write_reg(REG_TAPE_THRESHOLD, {junk[15:12], tape});
    write_reg(REG_CENTER_THRESHOLD, {junk[15:12], center});
    write_reg(REG_SETTLE_TIME, settle);
    write_reg(REG_FORWARD_SPEED, {junk[15], fwd});
    write_reg(REG_TURN_SPEED, {junk[15], turn});
    write_reg(REG_CRAWL_SPEED, {junk[15], crawl});
    if (dirty) begin
      write_reg(StrayIdxLo, junk);
      write_reg(StrayIdxHi, ~junk);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [LevelW-1:0] level_below(input logic [LevelW-1:0] th);
    return (th == 0) ? '0 : LevelW'($urandom_range(32'(th) - 1, 0));
  endfunction

  function automatic logic [LevelW-1:0] level_not_below(input logic [LevelW-1:0] th);
    return LevelW'($urandom_range(32'(LevelMax), 32'(th)));
  endfunction

  task automatic random_reading();
    logic [LevelW-1:0] left;
    logic [LevelW-1:0] center;
    logic [LevelW-1:0] right;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    // time mostly creeps forward around the settle window, sometimes jumps anywhere
    if (pick < 5) begin
      now_ms = $urandom();
    end else begin
      now_ms = now_ms + $urandom_range(2 * 32'(settle_ms) + 3, 0);
    end
    if (pick < 20) begin
      left   = LevelW'($urandom());
      center = LevelW'($urandom());
      right  = LevelW'($urandom());
    end else begin
      center = $urandom_range(0, 1) ? level_below(center_th) : level_not_below(center_th);
      left   = $urandom_range(0, 1) ? level_below(tape_th) : level_not_below(tape_th);
      right  = $urandom_range(0, 1) ? level_below(tape_th) : level_not_below(tape_th);
    end
    send_reading(left, center, right, now_ms);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_TAPE_THRESHOLD;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    left_level_i   = '0;
    center_level_i = '0;
    right_level_i  = '0;
    time_ms_i      = '0;
    no_idle        = 1'b0;
    beats_sent     = 0;
    reg_writes     = 0;
    tape_th        = TapeThresholdRst;
    center_th      = CenterThresholdRst;
    settle_ms      = SettleTimeRst;
    now_ms         = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed walk through every transition with the reset settings
    send_reading(LevelMax, 12'd0, LevelMax, 32'd100);
    send_reading(12'd0, LevelMax, LevelMax, 32'd1000);
    send_reading(LevelMax, 12'd0, LevelMax, 32'd1059);
    send_reading(LevelMax, 12'd0, LevelMax, 32'd1060);
    send_reading(LevelMax, 12'd1500, 12'd1999, 32'd2000);
    send_reading(12'd0, LevelMax, 12'd0, 32'd2100);
    send_reading(12'd0, 12'd1499, 12'd0, 32'd2101);
    send_reading(12'd0, 12'd2000, 12'd0, 32'd3000);
    send_reading(12'd10, LevelMax, 12'd20, 32'd3001);
    send_reading(LevelMax, 12'd0, LevelMax, 32'd3061);
    send_reading(LevelMax, LevelMax, LevelMax, 32'd3100);
    send_reading(12'd777, 12'd0, 12'd777, 32'd3101);
    send_reading(12'd0, 12'd0, 12'd0, 32'd3161);
    // settle window across the timestamp rollover
    send_reading(12'd0, LevelMax, LevelMax, 32'hFFFF_FFF0);
    send_reading(12'd0, 12'd0, 12'd0, 32'h0000_002B);
    send_reading(12'd0, 12'd0, 12'd0, 32'h0000_002C);
    send_reading(LevelMax, LevelMax, 12'd0, 32'hFFFF_FFFF);
    send_reading(LevelMax, 12'd0, LevelMax, 32'h0000_003B);

    // top thresholds, zero settle, full-scale speeds, junk in unused data bits
    load_follow_regs(LevelMax, LevelMax, '0, '1, '1, '1, 1'b1);
    send_reading(LevelMax - 1'b1, LevelMax, LevelMax, 32'd5);
    send_reading(12'd0, LevelMax - 1'b1, 12'd0, 32'd5);
    send_reading(LevelMax, LevelMax, LevelMax - 1'b1, 32'd6);
    send_reading(12'd0, 12'd0, 12'd0, 32'd6);

    // zero thresholds: nothing is ever dark enough
    load_follow_regs('0, '0, '1, '0, '0, '0, 1'b0);
    send_reading(12'd0, 12'd0, 12'd0, 32'd7);
    send_reading(12'd1, 12'd0, 12'd0, 32'd8);
    send_reading(12'd0, 12'd0, 12'd0, 32'd8);

    load_follow_regs(TapeThresholdRst, CenterThresholdRst, SettleTimeRst,
                     ForwardSpeedRst, TurnSpeedRst, CrawlSpeedRst, 1'b0);
    repeat (PhaseItems) random_reading();

    load_follow_regs(LevelW'($urandom()), LevelW'($urandom()), SettleW'($urandom_range(40, 0)),
                     SpeedW'($urandom()), SpeedW'($urandom()), SpeedW'($urandom()), 1'b1);
    repeat (PhaseItems) random_reading();

    // back-to-back beats on both channels
    load_follow_regs(LevelW'($urandom_range(3000, 1000)), LevelW'($urandom_range(3000, 1000)),
                     SettleW'($urandom_range(10, 0)),
                     SpeedW'($urandom()), SpeedW'($urandom()), SpeedW'($urandom()), 1'b0);
    no_idle = 1'b1;
    repeat (PhaseItems) random_reading();
    no_idle = 1'b0;

    load_follow_regs(LevelMax, 12'd1, '1, '1, 15'd1, '0, 1'b1);
    repeat (PhaseItems) random_reading();

    load_follow_regs(LevelW'($urandom()), LevelW'($urandom()),
                     ($urandom_range(0, 3) == 0) ? SettleW'($urandom()) :
                                                   SettleW'($urandom_range(20, 0)),
                     SpeedW'($urandom()), SpeedW'($urandom()), SpeedW'($urandom()), 1'b1);
    repeat (PhaseItems) random_reading();

    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    // keep clocking to catch stray output beats
    repeat (8) @(negedge clk_i);

    $display("sent %0d sensor beats, checked %0d result beats", beats_sent, checked_cnt);
    $display("%0d register writes in all, %0d mismatches", reg_writes, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
